// ===== rtl/dhm_pkg.sv =====
`default_nettype none
package dhm_pkg;
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam logic [31:0] TIME_WINDOW_RESET = 32'd500;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_MERGED  = 3'd1,
        ST_NEW     = 3'd2,
        ST_DROPPED = 3'd3,
        ST_RECORD  = 3'd4,
        ST_LAST    = 3'd5,
        ST_EMPTY   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_WRITE,
        S_OUT,
        S_FLUSH_RD,
        S_FLUSH_OUT
    } fsm_t;

    typedef struct packed {
        logic [4:0]  layer;
        logic [15:0] segment;
        logic [31:0] energy;
        logic [31:0] etime;
        logic [23:0] track;
        logic [31:0] particle;
        logic [62:0] position;
        logic [62:0] momentum;
        logic [63:0] local_position;
        logic [62:0] local_momentum;
        logic [31:0] path;
    } entry_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  volume_index;
        logic [15:0] copy_number;
        logic [31:0] energy_deposit;
        logic [31:0] hit_time;
        logic [23:0] track_number;
        logic signed [31:0] particle_code;
        logic [62:0] global_position;
        logic [62:0] momentum;
        logic [63:0] local_position;
        logic [62:0] local_momentum;
        logic [31:0] path_length;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        entry_t      entry;
    } result_t;

    function automatic logic [4:0] layer_of(input logic [2:0] v);
        logic [4:0] r;
        case (v)
            3'd0: r = 5'd0;
            3'd1: r = 5'd1;
            3'd2: r = 5'd2;
            3'd3: r = 5'd3;
            3'd4: r = 5'd11;
            3'd5: r = 5'd12;
            3'd6: r = 5'd13;
            default: r = 5'd20;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/dhm_if.sv =====
`default_nettype none
interface dhm_in_if;
    logic valid;
    logic ready;
    dhm_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dhm_out_if;
    logic valid;
    logic ready;
    dhm_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dhm_cfg_if;
    logic valid;
    logic ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dhm_store.sv =====
`default_nettype none
module dhm_store #(
    parameter int ENTRIES = dhm_pkg::TABLE_ENTRIES_DEF,
    parameter int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire dhm_pkg::entry_t wdata,
    input  wire logic [AW-1:0] raddr,
    output dhm_pkg::entry_t    rdata
);
    dhm_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/dhm_match.sv =====
`default_nettype none
module dhm_match (
    input  wire dhm_pkg::entry_t ent,
    input  wire logic [4:0]      layer,
    input  wire logic [23:0]     track,
    input  wire logic [31:0]     t,
    input  wire logic [31:0]     window,
    output logic                 hit,
    output logic                 earlier
);
    logic [31:0] diff;
    always_comb
    begin
        diff = (t > ent.etime) ? (t - ent.etime) : (ent.etime - t);
        hit = (ent.layer == layer) && (ent.track == track) && (diff <= window);
        earlier = t < ent.etime;
    end
endmodule
`default_nettype wire

// ===== rtl/detector_hit_merge_table.sv =====
`default_nettype none
// Channel  | Dir | Payload                  | Transaction when
// in_ch    | in  | item_t (step or flush)   | valid & ready at clk rise
// out_ch   | out | result_t (status, entry) | valid & ready at clk rise
// cfg_ch   | in  | time_window (32 bit)     | valid & ready at clk rise
// A step reads and then compares each stored entry in turn (memory read, then
// compare) until a match; at the end of the table it writes a new entry or drops
// the item, and the next item is accepted only once the result has drained.
// A flush waits for the output register to drain before each entry it emits
// (drain, read, output).
// Reset clears count and control and sets the window to TIME_WINDOW_RESET; table contents stay undefined.
// A stalled result holds in the output register; input waits until it drains.
module detector_hit_merge_table #(
    parameter int TABLE_ENTRIES = dhm_pkg::TABLE_ENTRIES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    dhm_in_if.sink   in_ch,
    dhm_out_if.source out_ch,
    dhm_cfg_if.sink  cfg_ch
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    dhm_pkg::fsm_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0] window_reg;
    dhm_pkg::item_t item_reg;
    logic [4:0] layer_reg;
    dhm_pkg::result_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;

    logic we;
    logic [AW-1:0] waddr;
    dhm_pkg::entry_t wdata, rdata, fresh;
    logic hit, earlier;
    logic [32:0] esum;

    // Window register: configuration must only arrive while idle; the block itself does not enforce this.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= dhm_pkg::TIME_WINDOW_RESET;
        end
        else if (cfg_ch.valid)
        begin
            window_reg <= cfg_ch.data;
        end
    end

    dhm_store #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rdata)
    );

    dhm_match u_match (
        .ent(rdata), .layer(layer_reg), .track(item_reg.track_number),
        .t(item_reg.hit_time), .window(window_reg), .hit(hit), .earlier(earlier)
    );

    assign in_ch.ready  = (state_reg == dhm_pkg::S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    always_comb
    begin
        fresh.layer          = layer_reg;
        fresh.segment        = item_reg.copy_number;
        fresh.energy         = item_reg.energy_deposit;
        fresh.etime          = item_reg.hit_time;
        fresh.track          = item_reg.track_number;
        fresh.particle       = item_reg.particle_code;
        fresh.position       = item_reg.global_position;
        fresh.momentum       = item_reg.momentum;
        fresh.local_position = item_reg.local_position;
        fresh.local_momentum = item_reg.local_momentum;
        fresh.path           = item_reg.path_length;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        we             = 1'b0;
        waddr          = idx_reg[AW-1:0];
        wdata          = fresh;
        esum           = {1'b0, rdata.energy} + {1'b0, item_reg.energy_deposit};
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            dhm_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (in_ch.valid && in_ch.ready)
                begin
                    if (in_ch.data.kind)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next = '0;
                            res_next.status = dhm_pkg::ST_EMPTY;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            state_next = dhm_pkg::S_FLUSH_RD;
                        end
                    end
                    else if (in_ch.data.energy_deposit == '0)
                    begin
                        res_next = '0;
                        res_next.status = dhm_pkg::ST_IGNORED;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = dhm_pkg::S_READ;
                    end
                end
            end
            dhm_pkg::S_READ:
            begin
                // Hold the address for the registered read.
                if (idx_reg == count_reg)
                begin
                    state_next = dhm_pkg::S_WRITE;
                end
                else
                begin
                    state_next = dhm_pkg::S_CMP;
                end
            end
            dhm_pkg::S_CMP:
            begin
                if (hit)
                begin
                    wdata = rdata;
                    wdata.energy = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
                    if (earlier)
                    begin
                        wdata.etime          = item_reg.hit_time;
                        wdata.position       = item_reg.global_position;
                        wdata.momentum       = item_reg.momentum;
                        wdata.local_position = item_reg.local_position;
                        wdata.local_momentum = item_reg.local_momentum;
                        wdata.path           = item_reg.path_length;
                    end
                    we = 1'b1;
                    res_next.status = dhm_pkg::ST_MERGED;
                    res_next.entry = wdata;
                    out_valid_next = 1'b1;
                    state_next = dhm_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = dhm_pkg::S_READ;
                end
            end
            dhm_pkg::S_WRITE:
            begin
                if (count_reg == FULL)
                begin
                    res_next = '0;
                    res_next.status = dhm_pkg::ST_DROPPED;
                end
                else
                begin
                    we = 1'b1;
                    count_next = count_reg + 1'b1;
                    res_next.status = dhm_pkg::ST_NEW;
                    res_next.entry = fresh;
                end
                out_valid_next = 1'b1;
                state_next = dhm_pkg::S_IDLE;
            end
            dhm_pkg::S_FLUSH_RD:
            begin
                if (!out_valid_reg)
                begin
                    state_next = dhm_pkg::S_FLUSH_OUT;
                end
            end
            dhm_pkg::S_FLUSH_OUT:
            begin
                res_next.entry = rdata;
                out_valid_next = 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                begin
                    res_next.status = dhm_pkg::ST_LAST;
                    count_next = '0;
                    state_next = dhm_pkg::S_IDLE;
                end
                else
                begin
                    res_next.status = dhm_pkg::ST_RECORD;
                    idx_next = idx_reg + 1'b1;
                    state_next = dhm_pkg::S_FLUSH_RD;
                end
            end
            default:
            begin
                state_next = dhm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhm_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg  <= in_ch.data;
            layer_reg <= dhm_pkg::layer_of(in_ch.data.volume_index);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dhm_checker.sv =====
`default_nettype none
module dhm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] out_status
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status))
        else $error("result dropped while stalled");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status != 3'd7)
        else $error("bad status");
endmodule

bind detector_hit_merge_table dhm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.data.status)
);
`default_nettype wire

// ===== tb/dhm_tb_pkg.sv =====
package dhm_tb_pkg;
    localparam int HIT_SLOTS = 32;

    typedef struct {
        dhm_pkg::entry_t slot [HIT_SLOTS];
        int     fill;
        logic [31:0] merge_window;
    } hit_table_t;
endpackage

// ===== tb/detector_hit_merge_table_tb.sv =====
module detector_hit_merge_table_tb;
    // Watchdog: cycles without any transaction on any channel before giving up.
    // A step searches at most 32 entries, and the result side stalls only for a
    // bounded random stretch, so STALL_LIMIT is ample.
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 150;
    // Let the block finish any pending work before a window write.
    localparam int SETTLE_CYCLES = 2 * dhm_tb_pkg::HIT_SLOTS + 8;

    logic clk;
    logic rst_n;

    dhm_in_if  in_ch ();
    dhm_out_if out_ch ();
    dhm_cfg_if cfg_ch ();

    detector_hit_merge_table u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Predictor state: our own copy of the hit table and window.
    dhm_tb_pkg::hit_table_t hits;
    dhm_pkg::result_t       pending_results [$];

    int  error_count;
    int  result_count;
    int  item_count;
    int  idle_cycles;
    bit  quiet_phase;     // set for the last stretch: no idling anywhere
    logic [2:0] first_status;   // predicted status of the first result of the last item

    // Directed rows: item plus optional typed expectation of the first result.
    typedef struct {
        dhm_pkg::item_t   item;
        bit               has_status;
        dhm_pkg::status_t want_status;
    } directed_row_t;

    directed_row_t directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Volume to layer code, kept independent of the package helper.
    function automatic logic [4:0] layer_code(input logic [2:0] v);
        logic [4:0] codes [8];
        codes = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd11, 5'd12, 5'd13, 5'd20};
        return codes[v];
    endfunction

    // Predict the results of one item and advance the model table.
    function automatic void predict_hits(input dhm_pkg::item_t it);
        dhm_pkg::result_t r;
        logic [4:0] lay;
        logic [31:0] diff;
        logic [32:0] sum;
        int         i;
        r = '0;
        if (it.kind)
        begin
            if (hits.fill == 0)
            begin
                r.status = dhm_pkg::ST_EMPTY;
                pending_results.push_back(r);
            end
            for (i = 0; i < hits.fill; i++)
            begin
                r.status = (i == hits.fill - 1) ? dhm_pkg::ST_LAST : dhm_pkg::ST_RECORD;
                r.entry  = hits.slot[i];
                pending_results.push_back(r);
            end
            hits.fill = 0;
            return;
        end
        if (it.energy_deposit == 0)
        begin
            r.status = dhm_pkg::ST_IGNORED;
            pending_results.push_back(r);
            return;
        end
        lay = layer_code(it.volume_index);
        for (i = 0; i < hits.fill; i++)
        begin
            if (hits.slot[i].layer == lay && hits.slot[i].track == it.track_number)
            begin
                diff = (it.hit_time > hits.slot[i].etime) ? it.hit_time - hits.slot[i].etime
                                                          : hits.slot[i].etime - it.hit_time;
                if (diff <= hits.merge_window)
                begin
                    sum = {1'b0, hits.slot[i].energy} + {1'b0, it.energy_deposit};
                    hits.slot[i].energy = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (it.hit_time < hits.slot[i].etime)
                    begin
                        hits.slot[i].etime          = it.hit_time;
                        hits.slot[i].position       = it.global_position;
                        hits.slot[i].momentum       = it.momentum;
                        hits.slot[i].local_position = it.local_position;
                        hits.slot[i].local_momentum = it.local_momentum;
                        hits.slot[i].path           = it.path_length;
                    end
                    r.status = dhm_pkg::ST_MERGED;
                    r.entry  = hits.slot[i];
                    pending_results.push_back(r);
                    return;
                end
            end
        end
        if (hits.fill >= dhm_tb_pkg::HIT_SLOTS)
        begin
            r.status = dhm_pkg::ST_DROPPED;
            pending_results.push_back(r);
            return;
        end
        r.entry.layer          = lay;
        r.entry.segment        = it.copy_number;
        r.entry.energy         = it.energy_deposit;
        r.entry.etime          = it.hit_time;
        r.entry.track          = it.track_number;
        r.entry.particle       = it.particle_code;
        r.entry.position       = it.global_position;
        r.entry.momentum       = it.momentum;
        r.entry.local_position = it.local_position;
        r.entry.local_momentum = it.local_momentum;
        r.entry.path           = it.path_length;
        hits.slot[hits.fill] = r.entry;
        hits.fill++;
        r.status = dhm_pkg::ST_NEW;
        pending_results.push_back(r);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random item content; tracks and times drawn from small pools so merges happen.
    function automatic dhm_pkg::item_t random_step(input int track_pool, input int time_span);
        dhm_pkg::item_t it;
        it.kind            = 1'b0;
        it.volume_index    = 3'($urandom_range(7, 0));
        it.copy_number     = 16'($urandom());
        it.energy_deposit  = ($urandom_range(15, 0) == 0) ? 32'd0 :
                             ($urandom_range(7, 0) == 0) ? 32'hF000_0000 | $urandom()
                                                         : $urandom_range(100000, 1);
        it.hit_time        = ($urandom_range(9, 0) == 0) ? $urandom()
                                                         : $urandom_range(time_span, 0);
        it.track_number    = ($urandom_range(9, 0) == 0) ? 24'($urandom())
                                                         : 24'($urandom_range(track_pool, 0));
        it.particle_code   = $urandom();
        it.global_position = 63'(rand64());
        it.momentum        = 63'(rand64());
        it.local_position  = rand64();
        it.local_momentum  = 63'(rand64());
        it.path_length     = $urandom();
        return it;
    endfunction

    function automatic dhm_pkg::item_t flush_item();
        dhm_pkg::item_t it;
        it = '0;
        it.kind = 1'b1;
        return it;
    endfunction

    task automatic report(input string field, input logic [63:0] want,
                          input logic [63:0] got);
        $display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
        error_count++;
    endtask

    task automatic check_result(input dhm_pkg::result_t want, input dhm_pkg::result_t got);
        if (got.status !== want.status)
            report("status", 64'(want.status), 64'(got.status));
        if (got.entry.layer !== want.entry.layer)
            report("layer_id", 64'(want.entry.layer), 64'(got.entry.layer));
        if (got.entry.segment !== want.entry.segment)
            report("segment_id", 64'(want.entry.segment), 64'(got.entry.segment));
        if (got.entry.energy !== want.entry.energy)
            report("energy_sum", 64'(want.entry.energy), 64'(got.entry.energy));
        if (got.entry.etime !== want.entry.etime)
            report("earliest_time", 64'(want.entry.etime), 64'(got.entry.etime));
        if (got.entry.track !== want.entry.track)
            report("entry_track", 64'(want.entry.track), 64'(got.entry.track));
        if (got.entry.particle !== want.entry.particle)
            report("entry_particle", 64'(want.entry.particle), 64'(got.entry.particle));
        if (got.entry.position !== want.entry.position)
            report("entry_position", 64'(want.entry.position), 64'(got.entry.position));
        if (got.entry.momentum !== want.entry.momentum)
            report("entry_momentum", 64'(want.entry.momentum), 64'(got.entry.momentum));
        if (got.entry.local_position !== want.entry.local_position)
            report("entry_local_position", want.entry.local_position,
                   got.entry.local_position);
        if (got.entry.local_momentum !== want.entry.local_momentum)
            report("entry_local_momentum", 64'(want.entry.local_momentum),
                   64'(got.entry.local_momentum));
        if (got.entry.path !== want.entry.path)
            report("entry_path", 64'(want.entry.path), 64'(got.entry.path));
    endtask

    // Idle the input side for a random burst; drop valid only when idling.
    task automatic gap_burst();
        int n;
        if (!quiet_phase && $urandom_range(3, 0) == 0)
        begin
            n = $urandom_range(9, 1);
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Send one item: hold valid until the handshake, then predict.
    task automatic send_item(input dhm_pkg::item_t it);
        int n;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        n = pending_results.size();
        predict_hits(it);
        first_status = pending_results[n].status;
        item_count++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the merge window while the block is idle.
    task automatic write_window(input logic [31:0] w);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        hits.merge_window = w;
        @(posedge clk);
    endtask

    task automatic add_row(input dhm_pkg::item_t it, input bit known,
                           input dhm_pkg::status_t st);
        directed_row_t row;
        row.item        = it;
        row.has_status  = known;
        row.want_status = st;
        directed_rows.push_back(row);
    endtask

    // Result side: random stalls, compare each transaction with the oldest prediction.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %p", $time,
                             out_ch.data);
                    error_count++;
                end
                else
                begin
                    check_result(pending_results.pop_front(), out_ch.data);
                end
            end
            if (!quiet_phase && $urandom_range(5, 0) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(9, 1) - 1) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no transaction on any channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: %0d idle cycles, %0d results still expected",
                         idle_cycles, pending_results.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Main stimulus.
    initial
    begin
        dhm_pkg::item_t it;
        dhm_pkg::item_t base;
        int    k;
        int    n;

        error_count = 0;
        result_count = 0;
        item_count = 0;
        quiet_phase = 1'b0;
        first_status = '0;
        hits.fill = 0;
        hits.merge_window = dhm_pkg::TIME_WINDOW_RESET;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty flush, zero energy, extremes, merge, saturation, window edge, drop.
        add_row(flush_item(), 1'b1, dhm_pkg::ST_EMPTY);
        base = '0;
        add_row(base, 1'b1, dhm_pkg::ST_IGNORED);     // zero energy is ignored
        base.energy_deposit = 32'hFFFF_FFF0;
        base.hit_time = 32'd1000;
        base.track_number = 24'hFFFFFF;
        base.particle_code = 32'sh8000_0000;
        base.global_position = '1;
        base.momentum = '1;
        base.local_position = '1;
        base.local_momentum = '1;
        base.path_length = '1;
        base.copy_number = 16'hFFFF;
        base.volume_index = 3'd7;
        add_row(base, 1'b1, dhm_pkg::ST_NEW);
        it = base;
        it.energy_deposit = 32'd100;                  // overflow saturates
        it.hit_time = 32'd600;                        // earlier: takes new time
        it.global_position = '0;
        add_row(it, 1'b1, dhm_pkg::ST_MERGED);
        it.hit_time = 32'd1100;                       // exactly at the window edge
        add_row(it, 1'b1, dhm_pkg::ST_MERGED);
        it.hit_time = 32'd1101;                       // one past the edge
        add_row(it, 1'b1, dhm_pkg::ST_NEW);
        for (k = 0; k < 8; k++)
        begin
            it = random_step(3, 2000);
            it.volume_index = 3'(k);
            if (it.energy_deposit == 0)
                it.energy_deposit = 32'd1;
            add_row(it, 1'b0, dhm_pkg::ST_IGNORED);
        end
        add_row(flush_item(), 1'b0, dhm_pkg::ST_IGNORED);
        // Fill the table past capacity to reach the dropped case.
        for (k = 0; k < dhm_tb_pkg::HIT_SLOTS + 1; k++)
        begin
            it = '0;
            it.energy_deposit = 32'd1;
            it.track_number = 24'(k);
            add_row(it, k == dhm_tb_pkg::HIT_SLOTS, dhm_pkg::ST_DROPPED);
        end
        add_row(flush_item(), 1'b0, dhm_pkg::ST_IGNORED);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item);
            if (directed_rows[i].has_status
                && first_status !== directed_rows[i].want_status)
            begin
                $display("%0t directed row %0d: expected status %0d, actual %0d", $time,
                         i, directed_rows[i].want_status, first_status);
                error_count++;
            end
            gap_burst();
        end

        // Random phases over several window settings, extremes included.
        for (k = 0; k < 4; k++)
        begin
            case (k)
                0: write_window(32'd0);
                1: write_window(32'hFFFF_FFFF);
                2: write_window($urandom_range(2000, 1));
                default:
                begin
                    write_window(dhm_pkg::TIME_WINDOW_RESET);
                    quiet_phase = 1'b1;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                if ($urandom_range(11, 0) == 0)
                    send_item(flush_item());
                else
                    send_item(random_step(4, 3000));
                gap_burst();
            end
            send_item(flush_item());
        end

        wait_drained();
        $display("covered %0d items and %0d results over four window settings",
                 item_count, result_count);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
